// ===== rtl/core/frame_rate_fixing_fifo_top_macros.svh =====
// assertion macros for the frame rate fixing fifo checker
// used by frf_checker, no other dependencies
`ifndef FRAME_RATE_FIXING_FIFO_TOP_MACROS_SVH
`define FRAME_RATE_FIXING_FIFO_TOP_MACROS_SVH

// same-cycle implication under reset
`define FRF_ASSERT_IMPLY(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error("frf check failed");

// next-cycle implication under reset
`define FRF_ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error("frf check failed");

`endif

// ===== rtl/core/frf_pkg.sv =====
// types and constants shared by the frame rate fixing fifo
// no dependencies
`default_nettype none

package frf_pkg;

	localparam int DEPTH_DEF       = 16;
	localparam int HANDLE_BITS_DEF = 32;
	localparam int HANDLE_W        = 32;
	localparam int LEVEL_W         = 5;
	localparam int CAP_W           = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} frf_cmd_t;

	typedef struct packed {
		frf_cmd_t              command;
		logic [HANDLE_W-1:0]   frame_handle;
	} frf_in_t;

	typedef struct packed {
		logic [HANDLE_W-1:0]   out_handle;
		logic                  out_valid;
		logic                  repeated;
		logic                  dropped_oldest;
		logic                  rejected;
		logic [LEVEL_W-1:0]    level;
	} frf_res_t;

	typedef struct packed {
		logic                  pop_hit;
		logic                  repeated;
		logic                  dropped_oldest;
		logic                  rejected;
		logic [LEVEL_W-1:0]    level;
	} frf_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/frf_mem.sv =====
// handle storage: one write port, one registered read port
// no package dependencies
`default_nettype none

module frf_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/frf_ctrl.sv =====
// queue control: capacity register, pointers, level and request stage
// depends on frf_pkg
`default_nettype none

module frf_ctrl
	import frf_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF,
	localparam int AW         = $clog2(DEPTH),
	localparam int CW         = $clog2(DEPTH + 1),
	localparam int CMPW       = (CW > CAP_W) ? CW : CAP_W
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CAP_W-1:0]       cfg_wdata,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire frf_in_t                in_data,
	input  wire logic                   advance,
	output logic                        valid_s1,
	output frf_flags_t                  flags_s1,
	output logic                        mem_we,
	output logic      [AW-1:0]          mem_waddr,
	output logic      [HANDLE_BITS-1:0] mem_wdata,
	output logic                        mem_re,
	output logic      [AW-1:0]          mem_raddr
);

	logic [CAP_W-1:0] capacity_q;
	logic [AW-1:0]    head_q, tail_q, head_d, tail_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CMPW-1:0]  cap_ext, eff_cap;
	logic             accept, is_push, is_null, full;
	frf_flags_t       flags_d;

	function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	assign in_ready  = !valid_s1 || advance;
	assign accept    = in_valid && in_ready;
	assign is_push   = (in_data.command == CMD_PUSH);
	assign mem_wdata = HANDLE_BITS'(in_data.frame_handle);
	assign is_null   = (mem_wdata == '0);

	assign cap_ext = CMPW'(capacity_q);
	assign eff_cap = (capacity_q == '0) ? CMPW'(1) :
		((cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext);
	assign full    = CMPW'(count_q) >= eff_cap;

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = tail_q;
		mem_raddr = head_q;
		flags_d   = '0;
		if (accept) begin
			if (is_push) begin
				if (is_null) begin
					flags_d.rejected = 1'b1;
				end else begin
					mem_we = 1'b1;
					tail_d = next_slot(tail_q);
					if (full) begin
						// evict oldest, level stays
						head_d                 = next_slot(head_q);
						flags_d.dropped_oldest = 1'b1;
					end else begin
						count_d = count_q + CW'(1);
					end
				end
			end else if (count_q == CW'(1)) begin
				mem_re           = 1'b1;
				flags_d.pop_hit  = 1'b1;
				flags_d.repeated = 1'b1;
			end else if (count_q != '0) begin
				mem_re          = 1'b1;
				flags_d.pop_hit = 1'b1;
				head_d          = next_slot(head_q);
				count_d         = count_q - CW'(1);
			end
		end
		flags_d.level = LEVEL_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1 <= flags_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/frame_rate_fixing_fifo_top.sv =====
// frame rate fixing fifo, top level: control, handle memory, result register
// depends on frf_pkg, frf_ctrl, frf_mem
//
//   port group   dir   handshake             payload
//   in           in    in_valid/in_ready     frf_in_t  in_data
//   res          out   res_valid/res_ready   frf_res_t res_data
//   cfg          in    cfg_we                cfg_wdata (capacity)
//
// one item per cycle while the result is not stalled; memory read and flags are taken
// at the input edge; the result register loads them and raises res_valid when free
// asynchronous reset clears pointers and level, sets capacity to 16; no clearing pass
// a stalled result holds the request stage; input is refused only while both are full
`default_nettype none

module frame_rate_fixing_fifo_top
	import frf_pkg::*;
#(
	parameter int DEPTH       = DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CAP_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire frf_in_t          in_data,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output frf_res_t              res_data
);

	localparam int AW = $clog2(DEPTH);

	logic                   valid_s1, advance;
	frf_flags_t             flags_s1;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [HANDLE_BITS-1:0] mem_wdata, mem_rdata;

	assign advance = valid_s1 && (!res_valid || res_ready);

	frf_ctrl #(
		.DEPTH       (DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.flags_s1  (flags_s1),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	frf_mem #(
		.DEPTH (DEPTH),
		.WIDTH (HANDLE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_data.out_handle     <= flags_s1.pop_hit ? HANDLE_W'(mem_rdata) : '0;
			res_data.out_valid      <= flags_s1.pop_hit;
			res_data.repeated       <= flags_s1.repeated;
			res_data.dropped_oldest <= flags_s1.dropped_oldest;
			res_data.rejected       <= flags_s1.rejected;
			res_data.level          <= flags_s1.level;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/frf_checker.sv =====
// port-level checks for the frame rate fixing fifo, bound to the top level
// depends on frf_pkg and frame_rate_fixing_fifo_top_macros.svh
`default_nettype none
`include "frame_rate_fixing_fifo_top_macros.svh"

module frf_checker
	import frf_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire frf_res_t         res_data
);

	logic res_pop, res_none, res_rep, res_stall;

	assign res_pop   = res_valid && res_data.out_valid;
	assign res_none  = res_valid && !res_data.out_valid;
	assign res_rep   = res_valid && res_data.repeated;
	assign res_stall = res_valid && !res_ready;

	// a pop result never carries push flags
	`FRF_ASSERT_IMPLY(a_pop_no_push_flags, clk, arst_n, res_pop, !res_data.dropped_oldest && !res_data.rejected)

	// a repeat only happens with a single entry held
	`FRF_ASSERT_IMPLY(a_repeat_level_one, clk, arst_n, res_rep, res_data.level == LEVEL_W'(1))

	// a returned handle is never null, and no handle means zero
	`FRF_ASSERT_IMPLY(a_handle_nonnull, clk, arst_n, res_pop, res_data.out_handle != '0)
	`FRF_ASSERT_IMPLY(a_no_handle_zero, clk, arst_n, res_none, res_data.out_handle == '0)

	// a stalled result transfer holds
	`FRF_ASSERT_NEXT(a_res_hold, clk, arst_n, res_stall, res_valid && $stable(res_data))

endmodule

bind frame_rate_fixing_fifo_top frf_checker u_frf_checker (.*);

`default_nettype wire
